### rtl/fixed_block_pool_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block pool allocator
// Clocked implication checks, same-cycle and next-cycle forms.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// pre holds -> post holds in the same cycle
`define FBPA_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// pre holds -> post holds in the next cycle
`define FBPA_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

### rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Types, codes and fixed widths shared by the block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   localparam int ADDR_W    = 32;
   localparam int BSIZE_W   = 16;
   localparam int COUNT_W   = 9;
   localparam int SPAN_W    = BSIZE_W + COUNT_W;
   localparam int QUO_W     = COUNT_W;
   localparam int STEP_W    = $clog2(QUO_W + 1);
   localparam int CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      MODE_ALLOC  = 2'd0,
      MODE_FREE   = 2'd1,
      MODE_CREATE = 2'd2,
      MODE_NONE   = 2'd3
   } fbpa_mode_type;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_NULL_BASE  = 3'd1,
      STATUS_BAD_SIZE   = 3'd2,
      STATUS_BAD_BLOCK  = 3'd3,
      STATUS_BAD_COUNT  = 3'd4,
      STATUS_NO_POOL    = 3'd5,
      STATUS_RANGE      = 3'd6,
      STATUS_EMPTY      = 3'd7
   } fbpa_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POOL_BASE   = 2'd0,
      CSR_POOL_BYTES  = 2'd1,
      CSR_BLOCK_BYTES = 2'd2,
      CSR_BLOCK_COUNT = 2'd3
   } fbpa_csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CREATE,
      S_ALLOC,
      S_ALLOC_ADD,
      S_FREE_CHK,
      S_FREE_DIV,
      S_FINISH
   } fbpa_state_type;

   typedef struct packed {
      fbpa_mode_type       mode;
      logic [ADDR_W-1:0]   address;
   } fbpa_req_type;

   typedef struct packed {
      fbpa_status_type     status;
      logic [ADDR_W-1:0]   block_address;
   } fbpa_rsp_type;

   typedef struct packed {
      logic                start;
      logic [SPAN_W-1:0]   dividend;
      logic [BSIZE_W-1:0]  divisor;
   } fbpa_div_req_type;

   typedef struct packed {
      logic                done;
      logic [QUO_W-1:0]    quotient;
   } fbpa_div_rsp_type;

endpackage

### rtl/fbpa_link_mem.sv
// ----------------------------------------------------------------------------
// fbpa_link_mem
// Free-list link store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fbpa_link_mem
   import fbpa_pkg::*;
#(
   parameter int DEPTH     = 256,
   parameter int ADDR_BITS = 8,
   parameter int WIDTH     = 9
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fbpa_div.sv
// ----------------------------------------------------------------------------
// fbpa_div
// Restoring divider, one quotient bit per cycle. The dividend must be below
// divisor * 2^QUO_W, which holds for any offset inside the pool.
// ----------------------------------------------------------------------------
module fbpa_div
   import fbpa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  fbpa_div_req_type div_req,
   output fbpa_div_rsp_type div_rsp
);

   logic [SPAN_W-1:0] rem_ff, rem_in;
   logic [SPAN_W-1:0] dsr_ff, dsr_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         dsr_in  = SPAN_W'(div_req.divisor) << (QUO_W - 1);
         quo_in  = '0;
         step_in = STEP_W'(QUO_W);
      end else if (step_ff != '0) begin
         if (rem_ff >= dsr_ff) begin
            rem_in = rem_ff - dsr_ff;
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         dsr_in  = dsr_ff >> 1;
         step_in = step_ff - STEP_W'(1);
         done_in = (step_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

### rtl/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator with a last-in-first-out free list held in
// a single-port-read, single-port-write link memory. One request is worked at
// a time; the result sits in an output register, so the next request is taken
// while that result waits. An ignored mode, a no-pool answer, a free of
// address zero or an empty pool go straight to the finish state; a create
// checks the settings; an allocate does a link read, index times block size
// and a base add; a free checks the range and, inside the pool, waits for the
// restoring divider, which yields one of nine quotient bits a cycle.
// The link memory needs no clearing after reset or create: only entries
// written by a free are ever read, and unused blocks come from a watermark.
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Top level: configuration registers, request sequencer and output register.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_macros.svh"

module fixed_block_pool_allocator
   import fbpa_pkg::*;
#(
   parameter int MAX_BLOCKS = 256,
   parameter int WORD_BYTES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fbpa_req_type         req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fbpa_rsp_type         rsp_payload,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata
);

   localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int LINK_W = IDX_W + 1;
   localparam logic [BSIZE_W-1:0] MIN_BLOCK = BSIZE_W'(WORD_BYTES);
   localparam logic [ADDR_W-1:0]  MAX_COUNT = ADDR_W'(MAX_BLOCKS);

   // configuration registers
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [ADDR_W-1:0]  bytes_ff, bytes_in;
   logic [BSIZE_W-1:0] bsize_ff, bsize_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // live pool
   logic [ADDR_W-1:0]  cur_base_ff, cur_base_in;
   logic [BSIZE_W-1:0] cur_block_ff, cur_block_in;
   logic [COUNT_W-1:0] cur_count_ff, cur_count_in;
   logic [SPAN_W-1:0]  cur_span_ff, cur_span_in;
   logic               pool_ready_ff, pool_ready_in;
   logic               head_empty_ff, head_empty_in;
   logic [IDX_W-1:0]   head_idx_ff, head_idx_in;
   logic [COUNT_W-1:0] watermark_ff, watermark_in;

   // working registers
   fbpa_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               from_list_ff, from_list_in;
   logic [ADDR_W-1:0]  prod_ff, prod_in;
   logic [ADDR_W-1:0]  offset_ff, offset_in;
   fbpa_status_type    res_status_ff, res_status_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   fbpa_rsp_type       rsp_payload_ff, rsp_payload_in;

   // link memory and divider
   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   logic [LINK_W-1:0]  mem_wr_data;
   logic               mem_rd_en;
   logic [IDX_W-1:0]   mem_rd_addr;
   logic [LINK_W-1:0]  mem_rd_data;
   fbpa_div_req_type   div_req;
   fbpa_div_rsp_type   div_rsp;
   logic [IDX_W-1:0]   div_idx;
   logic               req_beat;

   fbpa_link_mem #(
      .DEPTH     (MAX_BLOCKS),
      .ADDR_BITS (IDX_W),
      .WIDTH     (LINK_W)
   ) u_link_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   fbpa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign div_idx   = IDX_W'(div_rsp.quotient);

   always_comb begin
      base_in  = base_ff;
      bytes_in = bytes_ff;
      bsize_in = bsize_ff;
      count_in = count_ff;
      if (csr_write_en) begin
         case (fbpa_csr_type'(csr_index))
            CSR_POOL_BASE:   base_in  = csr_wdata;
            CSR_POOL_BYTES:  bytes_in = csr_wdata;
            CSR_BLOCK_BYTES: bsize_in = csr_wdata[BSIZE_W-1:0];
            CSR_BLOCK_COUNT: count_in = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      cur_base_in    = cur_base_ff;
      cur_block_in   = cur_block_ff;
      cur_count_in   = cur_count_ff;
      cur_span_in    = cur_span_ff;
      pool_ready_in  = pool_ready_ff;
      head_empty_in  = head_empty_ff;
      head_idx_in    = head_idx_ff;
      watermark_in   = watermark_ff;
      idx_in         = idx_ff;
      from_list_in   = from_list_ff;
      prod_in        = prod_ff;
      offset_in      = offset_ff;
      res_status_in  = res_status_ff;
      res_addr_in    = res_addr_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = div_idx;
      mem_wr_data    = {head_empty_ff, head_idx_ff};
      mem_rd_en      = 1'b0;
      mem_rd_addr    = head_idx_ff;
      div_req.start    = 1'b0;
      div_req.dividend = offset_ff[SPAN_W-1:0];
      div_req.divisor  = cur_block_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               res_addr_in = '0;
               state_in    = S_FINISH;
               case (req_payload.mode)
                  MODE_CREATE: begin
                     prod_in  = ADDR_W'(bsize_ff) * ADDR_W'(count_ff);
                     state_in = S_CREATE;
                  end
                  MODE_NONE: begin
                     res_status_in = STATUS_OK;
                  end
                  MODE_ALLOC: begin
                     if (!pool_ready_ff) begin
                        res_status_in = STATUS_NO_POOL;
                     end else if (!head_empty_ff) begin
                        mem_rd_en    = 1'b1;
                        idx_in       = head_idx_ff;
                        from_list_in = 1'b1;
                        state_in     = S_ALLOC;
                     end else if (watermark_ff < cur_count_ff) begin
                        idx_in       = IDX_W'(watermark_ff);
                        watermark_in = watermark_ff + COUNT_W'(1);
                        from_list_in = 1'b0;
                        state_in     = S_ALLOC;
                     end else begin
                        res_status_in = STATUS_EMPTY;
                     end
                  end
                  MODE_FREE: begin
                     if (!pool_ready_ff) begin
                        res_status_in = STATUS_NO_POOL;
                     end else if (req_payload.address == '0) begin
                        res_status_in = STATUS_OK;
                     end else begin
                        offset_in = req_payload.address - cur_base_ff;
                        state_in  = S_FREE_CHK;
                     end
                  end
                  default: begin
                     res_status_in = STATUS_OK;
                  end
               endcase
            end
         end

         S_CREATE: begin
            state_in = S_FINISH;
            if (base_ff == '0) begin
               res_status_in = STATUS_NULL_BASE;
            end else if (bytes_ff == '0) begin
               res_status_in = STATUS_BAD_SIZE;
            end else if (bsize_ff < MIN_BLOCK) begin
               res_status_in = STATUS_BAD_BLOCK;
            end else if (count_ff == '0 || ADDR_W'(count_ff) > MAX_COUNT) begin
               res_status_in = STATUS_BAD_COUNT;
            end else if (prod_ff > bytes_ff) begin
               res_status_in = STATUS_BAD_SIZE;
            end else begin
               res_status_in = STATUS_OK;
               cur_base_in   = base_ff;
               cur_block_in  = bsize_ff;
               cur_count_in  = count_ff;
               cur_span_in   = prod_ff[SPAN_W-1:0];
               pool_ready_in = 1'b1;
               head_empty_in = 1'b1;
               watermark_in  = '0;
            end
         end

         S_ALLOC: begin
            // link read lands this cycle when popping the list
            if (from_list_ff) begin
               head_empty_in = mem_rd_data[IDX_W];
               head_idx_in   = mem_rd_data[IDX_W-1:0];
            end
            prod_in  = ADDR_W'(idx_ff) * ADDR_W'(cur_block_ff);
            state_in = S_ALLOC_ADD;
         end

         S_ALLOC_ADD: begin
            res_status_in = STATUS_OK;
            res_addr_in   = cur_base_ff + prod_ff;
            state_in      = S_FINISH;
         end

         S_FREE_CHK: begin
            if (offset_ff >= ADDR_W'(cur_span_ff)) begin
               res_status_in = STATUS_RANGE;
               state_in      = S_FINISH;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_FREE_DIV;
            end
         end

         S_FREE_DIV: begin
            if (div_rsp.done) begin
               mem_wr_en     = 1'b1;
               head_empty_in = 1'b0;
               head_idx_in   = div_idx;
               res_status_in = STATUS_OK;
               state_in      = S_FINISH;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                 = 1'b1;
               rsp_payload_in.status        = res_status_ff;
               rsp_payload_in.block_address = res_addr_ff;
               state_in                     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         bytes_ff      <= '0;
         bsize_ff      <= '0;
         count_ff      <= '0;
         cur_base_ff   <= '0;
         cur_block_ff  <= '0;
         cur_count_ff  <= '0;
         cur_span_ff   <= '0;
         pool_ready_ff <= 1'b0;
         head_empty_ff <= 1'b1;
         head_idx_ff   <= '0;
         watermark_ff  <= '0;
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         base_ff       <= base_in;
         bytes_ff      <= bytes_in;
         bsize_ff      <= bsize_in;
         count_ff      <= count_in;
         cur_base_ff   <= cur_base_in;
         cur_block_ff  <= cur_block_in;
         cur_count_ff  <= cur_count_in;
         cur_span_ff   <= cur_span_in;
         pool_ready_ff <= pool_ready_in;
         head_empty_ff <= head_empty_in;
         head_idx_ff   <= head_idx_in;
         watermark_ff  <= watermark_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      from_list_ff   <= from_list_in;
      prod_ff        <= prod_in;
      offset_ff      <= offset_in;
      res_status_ff  <= res_status_in;
      res_addr_ff    <= res_addr_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `FBPA_ASSERT_IMP(a_watermark_in_pool, clock, reset, pool_ready_ff, watermark_ff <= cur_count_ff, "watermark beyond block count")
   `FBPA_ASSERT_IMP(a_list_needs_pool, clock, reset, !head_empty_ff, pool_ready_ff, "free list holds blocks without a pool")
   `FBPA_ASSERT_IMP(a_div_done_when_waiting, clock, reset, div_rsp.done, state_ff == S_FREE_DIV, "divider finished outside a free")
   `FBPA_ASSERT_IMP(a_error_no_address, clock, reset, rsp_valid_ff && rsp_payload_ff.status != STATUS_OK, rsp_payload_ff.block_address == '0, "error beat carries an address")
   `FBPA_ASSERT_NXT(a_free_pushes, clock, reset, state_ff == S_FREE_DIV && div_rsp.done, !head_empty_ff && state_ff == S_FINISH, "free did not push its block")

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fixed block pool allocator. A short table of
// requests walks the create checks, the no-pool answers, the free range test,
// misaligned and double frees, an empty pool and address wrap. Random pool
// settings with mostly well-formed allocate/free traffic follow. Every answer
// is compared with the table's expected answer or a local model of the pool
// under bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;
   import fbpa_pkg::*;

   localparam int MAX_BLOCKS    = 256;
   localparam int WORD_BYTES    = 4;
   localparam int RANDOM_ITEMS  = 500;
   localparam int SETTLE_CYCLES = 24;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int PRINT_LIMIT   = 30;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TRAIN} stall_kind_type;
   typedef enum int {
      FAULT_NULL_BASE, FAULT_NO_BYTES, FAULT_SMALL_BLOCK, FAULT_COUNT, FAULT_OVERSIZE
   } fault_kind_type;

   typedef struct {
      bit              is_csr;
      fbpa_csr_type    sel;
      logic [31:0]     value;
      fbpa_req_type    item;
      bit              typed;
      fbpa_rsp_type    want;
   } plan_row_type;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   fbpa_req_type         req_payload  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall    = 1'b0;
   fbpa_rsp_type         rsp_payload;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [ADDR_W-1:0]    csr_wdata    = '0;

   // pool model: registers as written, then the pool latched by create
   logic [31:0] reg_base  = '0;
   logic [31:0] reg_bytes = '0;
   logic [15:0] reg_bsize = '0;
   logic [8:0]  reg_count = '0;
   logic [8:0]  link_mem [MAX_BLOCKS];
   logic [8:0]  free_top   = 9'(MAX_BLOCKS);
   logic [8:0]  watermark  = '0;
   bit          pool_live  = 1'b0;
   logic [31:0] live_base  = '0;
   logic [15:0] live_bsize = '0;
   logic [8:0]  live_count = '0;
   int          handed_out [$];

   fbpa_rsp_type pending_answers [$];
   bit           item_typed = 1'b0;
   fbpa_rsp_type item_want  = '0;
   int           burst_left = 0;
   int           mismatches = 0;
   int           answers_checked = 0;
   int           requests_taken = 0;
   int           settings_tried = 0;
   int           status_seen [8];
   int           cycles = 0;
   stall_kind_type stall_kind = STALL_NONE;
   int           stall_left = 0;
   int           stall_tick = 0;

   fixed_block_pool_allocator #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .WORD_BYTES (WORD_BYTES)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timed out after %0d cycles, %0d answers still due", cycles,
                  pending_answers.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic fbpa_rsp_type predict_pool_answer(fbpa_req_type r);
      fbpa_rsp_type a;
      logic [31:0]  offset;
      logic [63:0]  span;
      int           idx;
      a.status = STATUS_OK;
      a.block_address = '0;
      idx = -1;
      if (r.mode == MODE_CREATE) begin
         if (reg_base == '0) a.status = STATUS_NULL_BASE;
         else if (reg_bytes == '0) a.status = STATUS_BAD_SIZE;
         else if (reg_bsize < WORD_BYTES) a.status = STATUS_BAD_BLOCK;
         else if (reg_count == '0 || reg_count > MAX_BLOCKS) a.status = STATUS_BAD_COUNT;
         else if (64'(reg_bsize) * 64'(reg_count) > 64'(reg_bytes)) a.status = STATUS_BAD_SIZE;
         else begin
            live_base  = reg_base;
            live_bsize = reg_bsize;
            live_count = reg_count;
            free_top   = 9'(MAX_BLOCKS);
            watermark  = '0;
            pool_live  = 1'b1;
            handed_out.delete();
         end
      end else if (r.mode == MODE_NONE) begin
         a.status = STATUS_OK;
      end else if (!pool_live) begin
         a.status = STATUS_NO_POOL;
      end else if (r.mode == MODE_ALLOC) begin
         if (free_top < MAX_BLOCKS) begin
            idx = free_top;
            free_top = link_mem[idx];
         end else if (watermark < live_count) begin
            idx = watermark;
            watermark++;
         end
         if (idx < 0) a.status = STATUS_EMPTY;
         else begin
            a.block_address = live_base + 32'(idx) * 32'(live_bsize);
            handed_out.push_back(idx);
         end
      end else if (r.address != '0) begin
         // offset taken modulo 2^32, so addresses below the base land far out
         offset = r.address - live_base;
         span = 64'(live_bsize) * 64'(live_count);
         if (64'(offset) >= span) a.status = STATUS_RANGE;
         else begin
            idx = offset / live_bsize;
            link_mem[idx] = free_top;
            free_top = 9'(idx);
         end
      end
      return a;
   endfunction

   function automatic fbpa_req_type next_request();
      fbpa_req_type r;
      int           pick;
      int           k;
      int           idx;
      int           offs;
      r.mode = MODE_FREE;
      r.address = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         r.mode = MODE_ALLOC;
      end else if (pick < 80) begin
         if (handed_out.size() != 0 && $urandom_range(0, 9) != 0) begin
            k = $urandom_range(0, handed_out.size() - 1);
            idx = handed_out[k];
            // now and then the block stays listed and gets freed twice
            if ($urandom_range(0, 7) != 0) handed_out.delete(k);
         end else begin
            idx = $urandom_range(0, (live_count == 0) ? 0 : int'(live_count) - 1);
         end
         offs = (live_bsize > 1 && $urandom_range(0, 3) == 0) ?
                $urandom_range(1, int'(live_bsize) - 1) : 0;
         r.address = live_base + 32'(idx) * 32'(live_bsize) + 32'(offs);
      end else if (pick < 85) begin
         r.address = '0;
      end else if (pick < 89) begin
         r.address = ($urandom_range(0, 1) == 0) ? live_base - 32'd1 :
                     live_base + 32'(live_bsize) * 32'(live_count);
      end else if (pick < 92) begin
         r.mode = MODE_NONE;
      end else if (pick < 95) begin
         r.mode = MODE_CREATE;
      end
      return r;
   endfunction

   function automatic plan_row_type csr_row(fbpa_csr_type sel, logic [31:0] value);
      plan_row_type row;
      row.is_csr = 1'b1;
      row.sel    = sel;
      row.value  = value;
      row.item   = '0;
      row.typed  = 1'b0;
      row.want   = '0;
      return row;
   endfunction

   function automatic plan_row_type req_row(fbpa_mode_type mode, logic [31:0] address, bit typed,
                                            fbpa_status_type status,
                                            logic [31:0] block_address);
      plan_row_type row;
      row.is_csr             = 1'b0;
      row.sel                = CSR_POOL_BASE;
      row.value              = '0;
      row.item.mode          = mode;
      row.item.address       = address;
      row.typed              = typed;
      row.want.status        = status;
      row.want.block_address = block_address;
      return row;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("mismatch at answer %0d: %s got %0h want %0h", answers_checked, what, got,
                  want);
   endtask

   // entered and left on a falling edge; valid stays up inside a burst
   task automatic send_item(fbpa_req_type item, bit typed, fbpa_rsp_type want);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
                      $urandom_range(1, 12);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= item;
      item_typed  <= typed;
      item_want   <= want;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(fbpa_csr_type sel, logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= sel;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure_random();
      logic [31:0] base;
      logic [31:0] bytes;
      logic [15:0] bsize;
      logic [8:0]  count;
      int          pick;
      base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 4095)) :
             $urandom;
      if (base == '0) base = 32'h1;
      pick = $urandom_range(0, 7);
      if (pick == 0) bsize = 16'hFFFF;
      else if (pick == 1) bsize = 16'(WORD_BYTES);
      else bsize = 16'($urandom_range(WORD_BYTES, 160));
      count = ($urandom_range(0, 7) == 0) ? 9'(MAX_BLOCKS) : 9'($urandom_range(1, 12));
      bytes = 32'(bsize) * 32'(count);
      pick = $urandom_range(0, 3);
      if (pick == 1) bytes = 32'hFFFF_FFFF;
      else if (pick > 1) bytes += 32'($urandom_range(1, 1000));
      if ($urandom_range(0, 4) == 0)
         case (fault_kind_type'($urandom_range(0, 4)))
            FAULT_NULL_BASE:   base = '0;
            FAULT_NO_BYTES:    bytes = '0;
            FAULT_SMALL_BLOCK: bsize = 16'($urandom_range(0, WORD_BYTES - 1));
            FAULT_COUNT:       count = ($urandom_range(0, 1) == 0) ? 9'd0 :
                                       9'($urandom_range(MAX_BLOCKS + 1, 511));
            FAULT_OVERSIZE:    bytes = 32'(bsize) * 32'(count) - 32'd1;
            default: ;
         endcase
      // junk above the narrow fields must be dropped
      write_csr(CSR_POOL_BASE, base);
      write_csr(CSR_POOL_BYTES, bytes);
      write_csr(CSR_BLOCK_BYTES, {16'($urandom), bsize});
      write_csr(CSR_BLOCK_COUNT, {23'($urandom), count});
      settings_tried++;
   endtask

   always @(negedge clock) begin : receiver
      if (stall_left == 0) begin
         stall_kind = stall_kind_type'($urandom_range(0, 3));
         stall_left = $urandom_range(24, 160);
      end
      stall_left--;
      stall_tick++;
      case (stall_kind)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         STALL_TRAIN: rsp_stall <= (stall_tick % 7 < 4);
         default:     rsp_stall <= 1'b0;
      endcase
   end

   always @(posedge clock) begin : scoreboard
      fbpa_rsp_type predicted;
      fbpa_rsp_type want;
      if (!reset) begin
         if (csr_write_en)
            case (csr_index)
               CSR_POOL_BASE:   reg_base  = csr_wdata;
               CSR_POOL_BYTES:  reg_bytes = csr_wdata;
               CSR_BLOCK_BYTES: reg_bsize = csr_wdata[15:0];
               CSR_BLOCK_COUNT: reg_count = csr_wdata[8:0];
               default: ;
            endcase
         if (req_valid && !req_stall) begin
            predicted = predict_pool_answer(req_payload);
            pending_answers.push_back(item_typed ? item_want : predicted);
            status_seen[int'(predicted.status)]++;
            requests_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               report_mismatch("beat with nothing due, address", rsp_payload.block_address,
                               '0);
            end else begin
               want = pending_answers.pop_front();
               answers_checked++;
               if (rsp_payload.status !== want.status)
                  report_mismatch("status", 32'(rsp_payload.status), 32'(want.status));
               if (rsp_payload.block_address !== want.block_address)
                  report_mismatch("block_address", rsp_payload.block_address,
                                  want.block_address);
            end
         end
      end
   end

   initial begin : stimulus
      plan_row_type plan [$];
      fbpa_req_type create_req;
      int           rand_items;
      int           n;

      // nothing configured yet
      plan.push_back(req_row(MODE_ALLOC, 32'h0, 1, STATUS_NO_POOL, 32'h0));
      plan.push_back(req_row(MODE_FREE, 32'h0, 1, STATUS_NO_POOL, 32'h0));
      plan.push_back(req_row(MODE_NONE, 32'hFFFF_FFFF, 1, STATUS_OK, 32'h0));
      plan.push_back(req_row(MODE_CREATE, 32'h0, 1, STATUS_NULL_BASE, 32'h0));
      // create checks, one fault cleared at a time
      plan.push_back(csr_row(CSR_POOL_BASE, 32'hFFFF_FF00));
      plan.push_back(req_row(MODE_CREATE, 32'h0, 1, STATUS_BAD_SIZE, 32'h0));
      plan.push_back(csr_row(CSR_POOL_BYTES, 32'hFFFF_FFFF));
      plan.push_back(req_row(MODE_CREATE, 32'h0, 1, STATUS_BAD_BLOCK, 32'h0));
      plan.push_back(csr_row(CSR_BLOCK_BYTES, 32'd3));
      plan.push_back(req_row(MODE_CREATE, 32'h0, 1, STATUS_BAD_BLOCK, 32'h0));
      plan.push_back(csr_row(CSR_BLOCK_BYTES, 32'h0000_FFFF));
      plan.push_back(req_row(MODE_CREATE, 32'h0, 1, STATUS_BAD_COUNT, 32'h0));
      plan.push_back(csr_row(CSR_BLOCK_COUNT, 32'hFFFF_FFFF));
      plan.push_back(req_row(MODE_CREATE, 32'h0, 1, STATUS_BAD_COUNT, 32'h0));
      plan.push_back(csr_row(CSR_BLOCK_COUNT, 32'(MAX_BLOCKS)));
      plan.push_back(csr_row(CSR_POOL_BYTES, 32'h00FF_FEFF));
      plan.push_back(req_row(MODE_CREATE, 32'h0, 1, STATUS_BAD_SIZE, 32'h0));
      plan.push_back(req_row(MODE_FREE, 32'hFFFF_FF00, 1, STATUS_NO_POOL, 32'h0));
      // largest pool, reaching past the top of the address space
      plan.push_back(csr_row(CSR_POOL_BYTES, 32'h00FF_FF00));
      plan.push_back(req_row(MODE_CREATE, 32'h0, 1, STATUS_OK, 32'h0));
      plan.push_back(req_row(MODE_ALLOC, 32'h0, 1, STATUS_OK, 32'hFFFF_FF00));
      plan.push_back(req_row(MODE_ALLOC, 32'h0, 1, STATUS_OK, 32'h0000_FEFF));
      plan.push_back(req_row(MODE_FREE, 32'h0, 1, STATUS_OK, 32'h0));
      plan.push_back(req_row(MODE_FREE, 32'hFFFF_FEFF, 1, STATUS_RANGE, 32'h0));
      plan.push_back(req_row(MODE_FREE, 32'h00FF_FE00, 1, STATUS_RANGE, 32'h0));
      plan.push_back(req_row(MODE_FREE, 32'h0000_FF00, 0, STATUS_OK, 32'h0));
      plan.push_back(req_row(MODE_FREE, 32'h00FF_FDFF, 0, STATUS_OK, 32'h0));
      plan.push_back(req_row(MODE_FREE, 32'hFFFF_FFFF, 0, STATUS_OK, 32'h0));
      plan.push_back(req_row(MODE_FREE, 32'hFFFF_FF00, 0, STATUS_OK, 32'h0));
      plan.push_back(req_row(MODE_ALLOC, 32'h0, 0, STATUS_OK, 32'h0));
      plan.push_back(req_row(MODE_ALLOC, 32'h0, 0, STATUS_OK, 32'h0));
      // re-create over the live pool with a single block, then run it dry
      plan.push_back(csr_row(CSR_BLOCK_COUNT, 32'd1));
      plan.push_back(req_row(MODE_CREATE, 32'h0, 1, STATUS_OK, 32'h0));
      plan.push_back(req_row(MODE_ALLOC, 32'h0, 1, STATUS_OK, 32'hFFFF_FF00));
      plan.push_back(req_row(MODE_ALLOC, 32'h0, 1, STATUS_EMPTY, 32'h0));

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            settle();
            write_csr(plan[i].sel, plan[i].value);
         end else begin
            send_item(plan[i].item, plan[i].typed, plan[i].want);
         end
      end

      rand_items = 0;
      while (rand_items < RANDOM_ITEMS) begin
         settle();
         configure_random();
         create_req.mode = MODE_CREATE;
         create_req.address = $urandom;
         send_item(create_req, 1'b0, '0);
         n = $urandom_range(8, 60);
         repeat (n) send_item(next_request(), 1'b0, '0);
         rand_items += n + 1;
      end
      settle();

      $display("%0d requests, %0d answers compared, %0d random pool settings",
               requests_taken, answers_checked, settings_tried);
      $display("blocks handed out or freed ok %0d, empty %0d, out of range %0d, no pool %0d",
               status_seen[int'(STATUS_OK)], status_seen[int'(STATUS_EMPTY)],
               status_seen[int'(STATUS_RANGE)], status_seen[int'(STATUS_NO_POOL)]);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/fbpa_pkg.sv
rtl/fbpa_link_mem.sv
rtl/fbpa_div.sv
rtl/fixed_block_pool_allocator.sv
bench/testbench.sv
